// ===== design/bmp_dec_pkg.sv =====
`default_nettype none

package bmp_dec_pkg;

  // Default image limits.
  localparam int unsigned MaxWidthDefault  = 4096;
  localparam int unsigned MaxHeightDefault = 4096;

  // File layout: 14-byte file header followed by the 40-byte info header.
  localparam int unsigned HdrBytes      = 54;
  localparam int unsigned SigCheckBytes = 14;

  // Byte offsets of the header fields that the decoder uses.
  localparam int unsigned OffSignature = 0;
  localparam int unsigned OffPixOffset = 10;
  localparam int unsigned OffInfoSize  = 14;
  localparam int unsigned OffWidth     = 18;
  localparam int unsigned OffHeight    = 22;
  localparam int unsigned OffBitCount  = 28;
  localparam int unsigned OffCompress  = 30;

  localparam logic [15:0] BmpSignature = 16'h4d42;
  localparam logic [31:0] MinInfoSize  = 32'd40;

  // Compression modes that the decoder cannot handle.
  localparam logic [31:0] CompRle8     = 32'h01;
  localparam logic [31:0] CompRle4     = 32'h02;
  localparam logic [31:0] CompCmykRle8 = 32'h0c;
  localparam logic [31:0] CompCmykRle4 = 32'h0d;

  localparam logic [15:0] Bits24 = 16'd24;
  localparam logic [15:0] Bits32 = 16'd32;

  localparam logic [7:0] OpaqueAlpha = 8'hFF;

  localparam int unsigned InTdataW   = 8;
  localparam int unsigned OutPayW    = 85;
  localparam int unsigned OutTdataW  = 88;
  localparam int unsigned ErrCodeLsb = 82;

  typedef enum logic [2:0] {
    ErrSignature   = 3'd0,
    ErrHeaderSmall = 3'd1,
    ErrCompressed  = 3'd2,
    ErrSizeRange   = 3'd3,
    ErrBitCount    = 3'd4,
    ErrTruncated   = 3'd5,
    ErrBadOffset   = 3'd6
  } err_code_e;

  typedef enum logic {
    KindPixel = 1'b0,
    KindError = 1'b1
  } result_kind_e;

  // Result payload; the last member sits in the lowest bits.
  typedef struct packed {
    logic [2:0]  error_code;
    logic [12:0] image_height;
    logic [12:0] image_width;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } out_payload_t;

endpackage

`default_nettype wire

// ===== design/bmp_stream_to_rgba_decoder_unit.sv =====
`default_nettype none

// Channel   Direction  tdata                              tuser          tlast
// s_axis    in         data_byte                          first_byte     final_byte
// m_axis    out        red..error_code (85 of 88 bits)    result_kind    last
//
// One byte is taken per cycle while s_axis is ready, with no gaps between files or pixels.
// A result appears on m_axis in the cycle after the byte that causes it.
// The single output register decouples the sides: s_axis stays ready while
// that register is empty or is being emptied in the same cycle.
// Reset puts the parser idle; bytes are ignored until one flagged first_byte.

module bmp_stream_to_rgba_decoder_unit #(
  parameter int unsigned MAX_WIDTH  = bmp_dec_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bmp_dec_pkg::MaxHeightDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [bmp_dec_pkg::InTdataW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                                s_axis_tuser_i,   // [0] first_byte
  input  wire logic                                s_axis_tlast_i,   // final_byte
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [43:32] pixel_x,
  // [55:44] pixel_y, [68:56] image_width, [81:69] image_height,
  // [84:82] error_code, [87:85] zero
  output logic [bmp_dec_pkg::OutTdataW-1:0]        m_axis_tdata_o,
  output logic                                     m_axis_tuser_o,   // [0] result_kind
  output logic                                     m_axis_tlast_o    // last
);

  import bmp_dec_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhHeader = 4'b0010,
    PhSkip   = 4'b0100,
    PhPixels = 4'b1000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [23:0]     pix_q, pix_d;
  logic [1:0]      bip_q, bip_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [1:0]      pad_q, pad_d;

  // Captured header fields.
  logic [15:0] sig_q;
  logic [31:0] ofs_q;
  logic [31:0] info_q;
  logic [31:0] wid_q;
  logic [31:0] hgt_q;
  logic [15:0] bits_q;
  logic [31:0] comp_q;

  logic         out_valid_q;
  out_payload_t out_pay_q;
  logic         out_kind_q;
  logic         out_last_q;

  logic [7:0] in_byte;
  logic       in_first;
  logic       in_final;
  logic       in_fire;

  phase_e          cur_phase;
  logic [31:0]     cur_pos;
  logic [23:0]     cur_pix;
  logic [1:0]      cur_bip;
  logic [ColW-1:0] cur_col;
  logic [RowW-1:0] cur_row;
  logic [1:0]      cur_pad;
  logic [31:0]     pos_inc;

  logic      is32;
  logic      hdr_bad;
  err_code_e hdr_code;
  logic      complete;
  logic      col_end;
  logic      row_end;
  logic      done;

  logic         res_valid;
  logic         res_kind;
  logic         res_last;
  out_payload_t res_pay;

  assign in_byte  = s_axis_tdata_i;
  assign in_first = s_axis_tuser_i;
  assign in_final = s_axis_tlast_i;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // A first byte restarts parsing as if the decoder had just been cleared.
  assign cur_phase = in_first ? PhHeader : phase_q;
  assign cur_pos   = in_first ? '0 : pos_q;
  assign cur_pix   = in_first ? '0 : pix_q;
  assign cur_bip   = in_first ? '0 : bip_q;
  assign cur_col   = in_first ? '0 : col_q;
  assign cur_row   = in_first ? '0 : row_q;
  assign cur_pad   = in_first ? '0 : pad_q;
  assign pos_inc   = cur_pos + 32'd1;

  assign is32 = (bits_q == Bits32);

  always_comb begin
    hdr_bad  = 1'b1;
    hdr_code = ErrHeaderSmall;
    priority if (info_q < MinInfoSize) begin
      hdr_code = ErrHeaderSmall;
    end else if (comp_q == CompRle8 || comp_q == CompRle4 ||
                 comp_q == CompCmykRle8 || comp_q == CompCmykRle4) begin
      hdr_code = ErrCompressed;
    end else if (wid_q == 32'd0 || hgt_q == 32'd0 ||
                 wid_q > 32'(MAX_WIDTH) || hgt_q > 32'(MAX_HEIGHT)) begin
      hdr_code = ErrSizeRange;
    end else if (bits_q != Bits24 && bits_q != Bits32) begin
      hdr_code = ErrBitCount;
    end else if (ofs_q < 32'(HdrBytes)) begin
      hdr_code = ErrBadOffset;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  assign complete = is32 ? (cur_bip == 2'd3) : (cur_bip == 2'd2);
  assign col_end  = ({1'b0, cur_col} + (ColW + 1)'(1)) >= wid_q[ColW:0];
  assign row_end  = ({1'b0, cur_row} + (RowW + 1)'(1)) >= hgt_q[RowW:0];
  assign done     = col_end && row_end;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    pix_d     = pix_q;
    bip_d     = bip_q;
    col_d     = col_q;
    row_d     = row_q;
    pad_d     = pad_q;
    res_valid = 1'b0;
    res_kind  = KindPixel;
    res_last  = 1'b0;
    res_pay   = '0;

    if (in_fire) begin
      phase_d = cur_phase;
      pos_d   = cur_pos;
      pix_d   = cur_pix;
      bip_d   = cur_bip;
      col_d   = cur_col;
      row_d   = cur_row;
      pad_d   = cur_pad;

      unique case (cur_phase)
        PhIdle: begin
        end
        PhHeader: begin
          pos_d = pos_inc;
          if (pos_inc == 32'(HdrBytes)) begin
            phase_d = (ofs_q == 32'(HdrBytes)) ? PhPixels : PhSkip;
          end
          priority if (pos_inc == 32'(SigCheckBytes) && sig_q != BmpSignature) begin
            res_valid          = 1'b1;
            res_pay.error_code = ErrSignature;
          end else if (pos_inc == 32'(HdrBytes) && hdr_bad) begin
            res_valid          = 1'b1;
            res_pay.error_code = hdr_code;
          end else if (in_final) begin
            res_valid          = 1'b1;
            res_pay.error_code = ErrTruncated;
          end else begin
          end
          if (res_valid) begin
            res_kind = KindError;
            res_last = 1'b1;
            phase_d  = PhIdle;
          end
        end
        PhSkip: begin
          pos_d = pos_inc;
          if (pos_inc == ofs_q) begin
            phase_d = PhPixels;
          end
          if (in_final) begin
            res_valid          = 1'b1;
            res_kind           = KindError;
            res_last           = 1'b1;
            res_pay.error_code = ErrTruncated;
            phase_d            = PhIdle;
          end
        end
        PhPixels: begin
          if (cur_pad != 2'd0) begin
            pad_d = cur_pad - 2'd1;
          end else if (!complete) begin
            unique case (cur_bip)
              2'd0:    pix_d[7:0]   = in_byte;
              2'd1:    pix_d[15:8]  = in_byte;
              default: pix_d[23:16] = in_byte;
            endcase
            bip_d = cur_bip + 2'd1;
          end else begin
            pix_d = '0;
            bip_d = '0;
            res_pay.red          = is32 ? cur_pix[23:16] : in_byte;
            res_pay.green        = cur_pix[15:8];
            res_pay.blue         = cur_pix[7:0];
            res_pay.alpha        = is32 ? in_byte : OpaqueAlpha;
            res_pay.pixel_x      = 12'(cur_col);
            res_pay.pixel_y      = hgt_q[11:0] - 12'd1 - 12'(cur_row);
            res_pay.image_width  = wid_q[12:0];
            res_pay.image_height = hgt_q[12:0];
            if (col_end) begin
              col_d = '0;
              if (!row_end) begin
                row_d = cur_row + RowW'(1);
                pad_d = is32 ? 2'd0 : wid_q[1:0];
              end
            end else begin
              col_d = cur_col + ColW'(1);
            end
            if (!(in_final && !done)) begin
              res_valid = 1'b1;
              res_last  = done;
              if (done) begin
                phase_d = PhIdle;
              end
            end
          end
          // A final byte anywhere before the end of the image truncates it;
          // a pixel completed by that byte is dropped.
          if (in_final && !(complete && cur_pad == 2'd0 && done)) begin
            res_valid = 1'b1;
            res_kind  = KindError;
            res_last  = 1'b1;
            res_pay   = '0;
            res_pay.error_code = ErrTruncated;
            phase_d   = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      pos_q       <= '0;
      pix_q       <= '0;
      bip_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pix_q   <= pix_d;
      bip_q   <= bip_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pad_q   <= pad_d;
      if (in_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_pay_q  <= res_pay;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  // Header bytes land straight in the field registers that use them.
  always_ff @(posedge clk_i) begin
    if (in_fire && cur_phase == PhHeader) begin
      for (int k = 0; k < 2; k++) begin
        if (cur_pos == 32'(OffSignature + k)) sig_q[8*k +: 8] <= in_byte;
        if (cur_pos == 32'(OffBitCount + k))  bits_q[8*k +: 8] <= in_byte;
      end
      for (int k = 0; k < 4; k++) begin
        if (cur_pos == 32'(OffPixOffset + k)) ofs_q[8*k +: 8]  <= in_byte;
        if (cur_pos == 32'(OffInfoSize + k))  info_q[8*k +: 8] <= in_byte;
        if (cur_pos == 32'(OffWidth + k))     wid_q[8*k +: 8]  <= in_byte;
        if (cur_pos == 32'(OffHeight + k))    hgt_q[8*k +: 8]  <= in_byte;
        if (cur_pos == 32'(OffCompress + k))  comp_q[8*k +: 8] <= in_byte;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - OutPayW)'(0), out_pay_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== design/bmp_dec_sva.sv =====
`default_nettype none

module bmp_dec_sva (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid_i,
  input wire logic                             s_axis_tready_o,
  input wire logic [bmp_dec_pkg::InTdataW-1:0] s_axis_tdata_i,
  input wire logic                             s_axis_tuser_i,
  input wire logic                             s_axis_tlast_i,
  input wire logic                             m_axis_tvalid_o,
  input wire logic                             m_axis_tready_i,
  input wire logic [bmp_dec_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input wire logic                             m_axis_tuser_o,
  input wire logic                             m_axis_tlast_o
);

  import bmp_dec_pkg::*;

  logic [2:0] out_code;
  assign out_code = m_axis_tdata_o[ErrCodeLsb +: 3];

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Every error ends the file.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KindError |-> m_axis_tlast_o)
    else $error("error result without last");

  // An error carries only a defined code; all pixel fields read as zero.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KindError |->
      m_axis_tdata_o[ErrCodeLsb-1:0] == '0 && out_code != 3'd7)
    else $error("malformed error result");

  // A pixel's error code field always reads as zero.
  a_pix_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KindPixel |-> out_code == ErrSignature)
    else $error("pixel result with error code");

  // A new result needs a byte transaction in the cycle before.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result without a byte transaction");

endmodule

bind bmp_stream_to_rgba_decoder_unit bmp_dec_sva u_bmp_dec_sva (.*);

`default_nettype wire

// ===== tb/bmp_stream_to_rgba_decoder_unit_tb.sv =====
module bmp_stream_to_rgba_decoder_unit_tb;
  import bmp_dec_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned RandomBytes   = 400;
  localparam int unsigned QuietBytes    = 320;
  localparam int unsigned HoldAfter     = 80;

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhSkip,
    PhPixels
  } parse_phase_e;

  typedef struct {
    result_kind_e kind;
    out_payload_t pay;
    logic         last;
  } decoded_result_t;

  class bmp_decode_scoreboard;
    parse_phase_e    phase;
    int unsigned     pos;
    logic [7:0]      hdr [HdrBytes];
    logic [23:0]     pix;
    logic [2:0]      bip;
    logic [31:0]     col;
    logic [31:0]     row;
    logic [1:0]      pad;
    decoded_result_t awaited_results[$];
    int unsigned     fails;

    function new();
      fails = 0;
      restart();
      phase = PhIdle;
    endfunction

    function void restart();
      pos = 0;
      pix = '0;
      bip = '0;
      col = '0;
      row = '0;
      pad = '0;
    endfunction

    function logic [15:0] hdr16(input int unsigned at);
      return {hdr[at+1], hdr[at]};
    endfunction

    function logic [31:0] hdr32(input int unsigned at);
      return {hdr16(at + 2), hdr16(at)};
    endfunction

    function void post_error(input err_code_e code);
      decoded_result_t r;
      r.kind = KindError;
      r.pay = '0;
      r.pay.error_code = code;
      r.last = 1'b1;
      awaited_results.push_back(r);
      phase = PhIdle;
    endfunction

    // Works out what one accepted input transaction causes on the output.
    function void note_byte(input logic [7:0] b, input logic first, input logic fin);
      logic [31:0]     w;
      logic [31:0]     h;
      logic [31:0]     comp;
      logic            wide;
      logic [2:0]      need;
      logic [7:0]      a;
      logic            done;
      decoded_result_t r;
      if (first) begin
        restart();
        phase = PhHeader;
      end
      if (phase == PhIdle) return;

      if (phase == PhHeader) begin
        if (pos < HdrBytes) hdr[pos] = b;
        pos++;
        if (pos == SigCheckBytes && hdr16(OffSignature) != BmpSignature) begin
          post_error(ErrSignature);
          return;
        end
        if (pos == HdrBytes) begin
          w = hdr32(OffWidth);
          h = hdr32(OffHeight);
          comp = hdr32(OffCompress);
          if (hdr32(OffInfoSize) < MinInfoSize) begin
            post_error(ErrHeaderSmall);
            return;
          end
          if (comp == CompRle8 || comp == CompRle4 || comp == CompCmykRle8 ||
              comp == CompCmykRle4) begin
            post_error(ErrCompressed);
            return;
          end
          if (w == 0 || h == 0 || w > MaxWidthDefault || h > MaxHeightDefault) begin
            post_error(ErrSizeRange);
            return;
          end
          if (hdr16(OffBitCount) != Bits24 && hdr16(OffBitCount) != Bits32) begin
            post_error(ErrBitCount);
            return;
          end
          if (hdr32(OffPixOffset) < HdrBytes) begin
            post_error(ErrBadOffset);
            return;
          end
          phase = (hdr32(OffPixOffset) == HdrBytes) ? PhPixels : PhSkip;
        end
        if (fin) post_error(ErrTruncated);
        return;
      end

      if (phase == PhSkip) begin
        pos++;
        if (pos == hdr32(OffPixOffset)) phase = PhPixels;
        if (fin) post_error(ErrTruncated);
        return;
      end

      w = hdr32(OffWidth);
      h = hdr32(OffHeight);
      wide = (hdr16(OffBitCount) == Bits32);
      need = wide ? 3'd4 : 3'd3;
      a = OpaqueAlpha;
      done = 1'b0;
      if (pad != 0) begin
        pad--;
        if (fin) post_error(ErrTruncated);
        return;
      end
      if (bip < 3) begin
        pix = pix | (24'(b) << (8 * bip));
        bip++;
      end else begin
        a = b;
        bip = 3'd4;
      end
      if (bip < need) begin
        if (fin) post_error(ErrTruncated);
        return;
      end

      r.kind = KindPixel;
      r.pay = '0;
      r.pay.red = pix[23:16];
      r.pay.green = pix[15:8];
      r.pay.blue = pix[7:0];
      r.pay.alpha = a;
      r.pay.pixel_x = col[11:0];
      r.pay.pixel_y = 12'(h - 1 - row);
      r.pay.image_width = w[12:0];
      r.pay.image_height = h[12:0];
      pix = '0;
      bip = '0;
      if (col + 1 >= w) begin
        col = '0;
        if (row + 1 >= h) begin
          done = 1'b1;
        end else begin
          row++;
          pad = wide ? 2'd0 : w[1:0];
        end
      end else begin
        col++;
      end
      // A final byte that does not end the image turns the pixel into an error.
      if (fin && !done) begin
        post_error(ErrTruncated);
        return;
      end
      r.last = done;
      if (done) phase = PhIdle;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(input logic [OutTdataW-1:0] tdata, input logic tuser,
                               input logic tlast);
      decoded_result_t e;
      out_payload_t    got;
      if (awaited_results.size() == 0) begin
        $error("result transaction with none expected: tuser %0h tdata %0h", tuser, tdata);
        fails++;
        return;
      end
      e = awaited_results.pop_front();
      got = tdata[OutPayW-1:0];
      compare_field("result_kind", e.kind, tuser);
      compare_field("red", e.pay.red, got.red);
      compare_field("green", e.pay.green, got.green);
      compare_field("blue", e.pay.blue, got.blue);
      compare_field("alpha", e.pay.alpha, got.alpha);
      compare_field("pixel_x", e.pay.pixel_x, got.pixel_x);
      compare_field("pixel_y", e.pay.pixel_y, got.pixel_y);
      compare_field("image_width", e.pay.image_width, got.image_width);
      compare_field("image_height", e.pay.image_height, got.image_height);
      compare_field("error_code", e.pay.error_code, got.error_code);
      compare_field("last", e.last, tlast);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  bmp_decode_scoreboard sb;
  logic [7:0]           file_q[$];
  int unsigned          sent_cnt = 0;
  int unsigned          stall_cycles = 0;
  logic                 gaps_on = 1'b0;
  logic                 rx_stall_on = 1'b0;
  logic                 hold_req = 1'b0;

  logic                 in_fire = 1'b0;
  logic                 out_fire = 1'b0;
  logic [7:0]           in_byte;
  logic                 in_first;
  logic                 in_fin;
  logic [OutTdataW-1:0] out_data;
  logic                 out_user;
  logic                 out_last;

  bmp_stream_to_rgba_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Handshakes are sampled mid-cycle, where every signal is settled, and
  // processed at the following rising edge, where the transaction happens.
  always @(negedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    in_byte = s_axis_tdata;
    in_first = s_axis_tuser;
    in_fin = s_axis_tlast;
    out_data = m_axis_tdata;
    out_user = m_axis_tuser;
    out_last = m_axis_tlast;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) sb.note_byte(in_byte, in_first, in_fin);
      if (out_fire) sb.check_result(out_data, out_user, out_last);
      if (in_fire || out_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the byte was taken, or later when a random gap follows.
  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    logic hit;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= f;
    s_axis_tlast <= l;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk_i);
      hit = s_axis_tready;
      @(posedge clk_i);
    end
    sent_cnt++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic put16(input int unsigned at, input logic [15:0] v);
    file_q[at] = v[7:0];
    file_q[at+1] = v[15:8];
  endtask

  task automatic put32(input int unsigned at, input logic [31:0] v);
    put16(at, v[15:0]);
    put16(at + 2, v[31:16]);
  endtask

  task automatic make_header(input logic [31:0] off, input logic [31:0] info,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bits, input logic [31:0] comp);
    file_q.delete();
    for (int i = 0; i < HdrBytes; i++) file_q.push_back(8'($urandom));
    put16(OffSignature, BmpSignature);
    put32(OffPixOffset, off);
    put32(OffInfoSize, info);
    put32(OffWidth, w);
    put32(OffHeight, h);
    put16(OffBitCount, bits);
    put32(OffCompress, comp);
  endtask

  // Gap bytes, pixel rows bottom-up, 24-bit row padding and trailing bytes.
  task automatic add_body(input int wd, input int ht, input logic [15:0] bits,
                          input int unsigned off, input int tail);
    for (int i = HdrBytes; i < off; i++) file_q.push_back(8'($urandom));
    for (int r = 0; r < ht; r++) begin
      for (int c = 0; c < wd * (bits / 8); c++) file_q.push_back(8'($urandom));
      if (bits == Bits24 && r != ht - 1) begin
        for (int p = 0; p < (wd & 3); p++) file_q.push_back(8'($urandom));
      end
    end
    for (int t = 0; t < tail; t++) file_q.push_back(8'($urandom));
  endtask

  task automatic build_good(input int wd, input int ht, input logic [15:0] bits,
                            input int unsigned off, input logic [31:0] comp, input int tail);
    make_header(off, MinInfoSize, wd, ht, bits, comp);
    add_body(wd, ht, bits, off, tail);
  endtask

  task automatic send_file(input int count, input logic fin);
    for (int i = 0; i < count; i++) begin
      send_byte(file_q[i], i == 0, fin && (i == count - 1));
    end
  endtask

  task automatic build_random_good();
    int          wd;
    int          ht;
    logic [15:0] bits;
    int unsigned off;
    logic [31:0] comp;
    wd = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    ht = $urandom_range(1, 3);
    bits = $urandom_range(0, 1) ? Bits32 : Bits24;
    off = HdrBytes + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    comp = $urandom_range(0, 1) ? $urandom : 32'd0;
    if (comp == CompRle8 || comp == CompRle4 || comp == CompCmykRle8 ||
        comp == CompCmykRle4) comp = 32'd0;
    build_good(wd, ht, bits, off, comp, $urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) put32(OffInfoSize, $urandom_range(32'hFFFFFFFF, 40));
  endtask

  task automatic build_random_bad_header();
    logic [31:0] v;
    build_random_good();
    case ($urandom_range(0, 5))
      0: file_q[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      1: put32(OffInfoSize, $urandom_range(0, 39));
      2: begin
        case ($urandom_range(0, 3))
          0: put32(OffCompress, CompRle8);
          1: put32(OffCompress, CompRle4);
          2: put32(OffCompress, CompCmykRle8);
          default: put32(OffCompress, CompCmykRle4);
        endcase
      end
      3: begin
        v = $urandom_range(0, 1) ? 32'd0 : $urandom_range(32'hFFFFFFFF, MaxWidthDefault + 1);
        put32($urandom_range(0, 1) ? OffWidth : OffHeight, v);
      end
      4: begin
        v = $urandom;
        if (v[15:0] == Bits24 || v[15:0] == Bits32) v = '0;
        put16(OffBitCount, v[15:0]);
      end
      default: put32(OffPixOffset, $urandom_range(0, HdrBytes - 1));
    endcase
  endtask

  initial begin
    int unsigned rnd_start;
    logic        hold_issued;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes that arrive with no file open are ignored, final flag or not.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);

    build_good(1, 1, Bits24, HdrBytes, 0, 0);
    send_file(file_q.size(), 1'b1);
    build_good(1, 1, Bits32, HdrBytes, 0, 0);
    for (int i = HdrBytes; i < file_q.size(); i++) file_q[i] = 8'hFF;
    send_file(file_q.size(), 1'b1);
    build_good(1, 1, Bits32, HdrBytes, 0, 1);
    for (int i = HdrBytes; i < file_q.size(); i++) file_q[i] = 8'h00;
    send_file(file_q.size(), 1'b0);
    // Uncommon compression values decode as plain RGB; the final flag lands on
    // a trailing byte after the last pixel.
    build_good(3, 2, Bits24, HdrBytes + 6, 32'd3, 2);
    send_file(file_q.size(), 1'b1);
    build_good(5, 3, Bits24, HdrBytes, 0, 1);
    send_file(file_q.size(), 1'b0);
    build_good(2, 2, Bits24, HdrBytes, 0, 2);
    send_file(file_q.size(), 1'b0);
    build_good(4, 2, Bits32, HdrBytes + 1, 0, 0);
    send_file(file_q.size(), 1'b0);

    // Header checks, one failing field at a time.
    build_good(1, 1, Bits24, HdrBytes, 0, 0);
    file_q[0] = 8'h00;
    send_file(SigCheckBytes, 1'b0);
    build_good(1, 1, Bits24, HdrBytes, 0, 0);
    file_q[1] = 8'hFF;
    send_file(SigCheckBytes, 1'b0);
    make_header(HdrBytes, 39, 1, 1, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, 0, 1, 1, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 1, Bits24, CompRle8);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 1, Bits32, CompRle4);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 1, Bits24, CompCmykRle8);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 1, Bits24, CompCmykRle4);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 0, 1, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 0, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, MaxWidthDefault + 1, 1, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 32'hFFFFFFFF, Bits24, 0);
    send_file(HdrBytes, 1'b0);
    make_header(HdrBytes, MinInfoSize, 1, 1, 16'hFFFF, 0);
    send_file(HdrBytes, 1'b0);
    make_header(0, MinInfoSize, 1, 1, Bits32, 0);
    send_file(HdrBytes, 1'b1);

    // Truncation in the header, the gap, the row padding and on a byte that
    // completes a pixel, then a file whose first byte is also its final one.
    build_good(3, 2, Bits24, HdrBytes + 4, 0, 0);
    send_file(5, 1'b1);
    send_file(HdrBytes + 2, 1'b1);
    send_file(HdrBytes + 4 + 10, 1'b1);
    send_file(HdrBytes + 4 + 3, 1'b1);
    send_file(1, 1'b1);
    // A new file aborts the one in progress in the middle of its pixels.
    build_good(4, 3, Bits32, HdrBytes, 0, 0);
    send_file(HdrBytes + 7, 1'b0);
    send_file(file_q.size(), 1'b1);

    // The largest dimensions: the first pixels only, then truncation or abort.
    build_good(MaxWidthDefault, 1, Bits32, HdrBytes, 0, 0);
    send_file(HdrBytes + 9, 1'b1);
    build_good(1, MaxHeightDefault, Bits24, HdrBytes, 0, 1);
    send_file(HdrBytes + 7, 1'b0);

    rnd_start = sent_cnt;
    hold_issued = 1'b0;
    while (sent_cnt - rnd_start < RandomBytes) begin
      if (sent_cnt - rnd_start > QuietBytes) begin
        gaps_on = 1'b0;
        rx_stall_on = 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      if (!hold_issued && sent_cnt - rnd_start > HoldAfter) begin
        // The receiver holds off while a pixel-heavy file streams in.
        hold_issued = 1'b1;
        build_good(8, 4, Bits32, HdrBytes, 0, 0);
        hold_req = 1'b1;
        send_file(file_q.size(), 1'b1);
      end else begin
        case ($urandom_range(0, 19))
          12, 13: begin
            build_random_good();
            send_file($urandom_range(1, file_q.size()), 1'b1);
          end
          14: begin
            build_random_good();
            send_file($urandom_range(1, file_q.size()), 1'b0);
          end
          15: begin
            build_random_bad_header();
            send_file(HdrBytes + $urandom_range(0, 4), $urandom_range(0, 1));
          end
          16: begin
            repeat ($urandom_range(3, 16)) begin
              send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            end
          end
          default: begin
            build_random_good();
            send_file(file_q.size(), $urandom_range(0, 2) != 0);
          end
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bmp_stream_to_rgba_decoder_unit.f =====
design/bmp_dec_pkg.sv
design/bmp_stream_to_rgba_decoder_unit.sv
design/bmp_dec_sva.sv
tb/bmp_stream_to_rgba_decoder_unit_tb.sv
